// File: sv/rccb_pkg.sv
// Shared types and constants of the raised-cosine color breather.
// No dependencies; every other file of the block imports this package.
package rccb_pkg;

    localparam int PERIOD_W  = 24;
    localparam int ELAPSED_W = 24;
    localparam int COLOR_W   = 8;
    localparam int DIV_CNT_W = 6;

    // Pi in Q2.30 and one in Q2.30.
    localparam logic [31:0] PI_Q30  = 32'd3373259426;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    // Start request from the sequencer to the shared divider.
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] nbits;
    } t_div_ctl;

    // Constant division by a Taylor divisor (2k)(2k+1): the power of two is shifted
    // off first, and the odd factor is divided through floor(2^(32+post) / odd).
    typedef struct packed {
        logic [1:0]  pre;
        logic [6:0]  odd;
        logic [2:0]  post;
        logic [31:0] recip;
    } t_tdiv_const;

    function automatic t_tdiv_const taylor_const(input logic [2:0] k);
        t_tdiv_const c;
        case (k)
            3'd1: c = '{pre: 2'd1, odd: 7'd3,   post: 3'd1, recip: 32'd2863311530};
            3'd2: c = '{pre: 2'd2, odd: 7'd5,   post: 3'd2, recip: 32'd3435973836};
            3'd3: c = '{pre: 2'd1, odd: 7'd21,  post: 3'd4, recip: 32'd3272356035};
            3'd4: c = '{pre: 2'd3, odd: 7'd9,   post: 3'd3, recip: 32'd3817748707};
            3'd5: c = '{pre: 2'd1, odd: 7'd55,  post: 3'd5, recip: 32'd2498890063};
            3'd6: c = '{pre: 2'd2, odd: 7'd39,  post: 3'd5, recip: 32'd3524075730};
            3'd7: c = '{pre: 2'd1, odd: 7'd105, post: 3'd6, recip: 32'd2617884828};
            default: c = '{pre: 2'd1, odd: 7'd3, post: 3'd1, recip: 32'd2863311530};
        endcase
        return c;
    endfunction

endpackage

// File: sv/rccb_in_if.sv
// Input channel of the color breather: one tick beat with the elapsed time.
// Depends on rccb_pkg.
interface rccb_in_if import rccb_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ELAPSED_W-1:0] elapsed_us;

    modport source(output valid, output elapsed_us, input ready);
    modport sink(input valid, input elapsed_us, output ready);
endinterface

// File: sv/rccb_out_if.sv
// Output channel of the color breather: one beat with three color levels.
// Depends on rccb_pkg.
interface rccb_out_if import rccb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;

    modport source(output valid, output red_out, output green_out, output blue_out,
                   input ready);
    modport sink(input valid, input red_out, input green_out, input blue_out,
                 output ready);
endinterface

// File: sv/rccb_div.sv
// Shared restoring divider, one quotient bit per cycle, 24-bit divisor.
// Depends on rccb_pkg (t_div_ctl). The dividend arrives left aligned.
module rccb_div import rccb_pkg::*; #(
    parameter int DIVW = 34
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_ctl             i_ctl,
    input  logic [DIVW-1:0]      i_dividend,
    input  logic [PERIOD_W-1:0]  i_divisor,
    output logic                 o_done,
    output logic [DIVW-1:0]      o_quot,
    output logic [PERIOD_W-1:0]  o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVW-1:0]      r_dvd;
    logic [PERIOD_W-1:0]  r_rem;
    logic [PERIOD_W-1:0]  r_div;

    logic [PERIOD_W:0]    partial;
    logic [PERIOD_W+1:0]  diff;
    logic                 qbit;
    logic [PERIOD_W-1:0]  n_rem;

    always_comb begin
        partial = {r_rem, r_dvd[DIVW-1]};
        diff    = {1'b0, partial} - {2'b00, r_div};
        qbit    = ~diff[PERIOD_W+1];
        // Both candidates stay below the divisor, so 24 bits hold them.
        n_rem   = qbit ? diff[PERIOD_W-1:0] : partial[PERIOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_ctl.nbits;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DIVW-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;
    assign o_rem  = r_rem;

endmodule

// File: sv/raised_cosine_color_breather.sv
// Raised-cosine color breather. Each tick beat adds its elapsed microseconds to a
// time kept modulo period_us, takes the phase floor(time * 2^PHASE_BITS / period),
// and scales the three peak colors by sin^2 of the phase angle, which is a Taylor
// series evaluated in Q2.30. One shared restoring divider (one bit per cycle) does
// the modulo and the phase division, and one registered 32x32 multiplier does the
// rest, including the constant divisions of the series, which use a reciprocal
// product and one correction step. The block takes one tick at a time: the spacing
// of accepted ticks is set mostly by the divider, which does the modulo and then the
// phase division, and by the seven series terms. The color beat waits in an output
// register once it is computed; the next tick is taken only after the sequencer has
// handed its result over, so a stalled sink also stalls the input. A period of zero
// behaves as a period of one.
// Depends on rccb_pkg, rccb_in_if, rccb_out_if and rccb_div.
module raised_cosine_color_breather import rccb_pkg::*; #(
    parameter int PHASE_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    rccb_in_if.sink     i_tick,
    rccb_out_if.source  o_glow
);

    localparam int DIVW      = PERIOD_W + PHASE_BITS;
    localparam int N_PHASE   = 1 << PHASE_BITS;
    localparam int HALF      = N_PHASE / 2;
    localparam int MOD_BITS  = PERIOD_W + 1;
    localparam int PH_BITS   = PERIOD_W + PHASE_BITS;

    localparam logic [1:0] REG_PERIOD = 2'd0;
    localparam logic [1:0] REG_RED    = 2'd1;
    localparam logic [1:0] REG_GREEN  = 2'd2;
    localparam logic [1:0] REG_BLUE   = 2'd3;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_MOD     = 5'd1;
    localparam logic [4:0] S_PHASE   = 5'd2;
    localparam logic [4:0] S_MULX    = 5'd3;
    localparam logic [4:0] S_MULX2   = 5'd4;
    localparam logic [4:0] S_X2      = 5'd5;
    localparam logic [4:0] S_TMUL    = 5'd6;
    localparam logic [4:0] S_TDIV_GO = 5'd7;
    localparam logic [4:0] S_TDIV    = 5'd8;
    localparam logic [4:0] S_SQ      = 5'd9;
    localparam logic [4:0] S_G       = 5'd10;
    localparam logic [4:0] S_CR      = 5'd11;
    localparam logic [4:0] S_CG      = 5'd12;
    localparam logic [4:0] S_CB      = 5'd13;
    localparam logic [4:0] S_CD      = 5'd14;
    localparam logic [4:0] S_CW      = 5'd15;
    localparam logic [4:0] S_TFIX    = 5'd16;

    // Configuration registers.
    logic [PERIOD_W-1:0] r_period;
    logic [COLOR_W-1:0]  r_red_peak;
    logic [COLOR_W-1:0]  r_green_peak;
    logic [COLOR_W-1:0]  r_blue_peak;

    // Sequencer and datapath registers.
    logic [4:0]            r_state;
    logic [4:0]            n_state;
    logic [PERIOD_W-1:0]   r_time;
    logic [PERIOD_W-1:0]   r_p;
    logic [PHASE_BITS-1:0] r_q;
    logic [31:0]           r_term;
    logic [31:0]           r_x2;
    logic signed [33:0]    r_sum;
    logic [2:0]            r_k;
    logic [7:0]            r_num_lo;
    logic [31:0]           r_qe;
    logic [15:0]           r_g;
    logic [63:0]           r_prod;
    logic [COLOR_W-1:0]    r_lvl_r;
    logic [COLOR_W-1:0]    r_lvl_g;
    logic [COLOR_W-1:0]    r_lvl_b;
    logic                  r_out_valid;
    logic [COLOR_W-1:0]    r_red_out;
    logic [COLOR_W-1:0]    r_green_out;
    logic [COLOR_W-1:0]    r_blue_out;

    logic                  cfg_wr;
    logic                  tick_acc;
    logic                  out_free;
    logic [PERIOD_W-1:0]   p_eff;
    logic [MOD_BITS-1:0]   mod_sum;
    logic [PHASE_BITS-1:0] phase;
    logic [PHASE_BITS:0]   phase_ext;
    logic [PHASE_BITS:0]   fold;
    logic [31:0]           x_val;
    t_tdiv_const           tdc;
    logic [31:0]           tdiv_num;
    logic [31:0]           q_est;
    logic [7:0]            rem_lo;
    logic [31:0]           term_q;
    logic [30:0]           s_val;
    logic [60:0]           g_round;
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;

    t_div_ctl              div_ctl;
    logic [DIVW-1:0]       div_dividend;
    logic [PERIOD_W-1:0]   div_divisor;
    logic                  div_done;
    logic [DIVW-1:0]       div_quot;
    logic [PERIOD_W-1:0]   div_rem;

    rccb_div #(
        .DIVW(DIVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    // APB register file; only the upper address bits select a register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period     <= PERIOD_W'(2000000);
            r_red_peak   <= '0;
            r_green_peak <= '0;
            r_blue_peak  <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_PERIOD: r_period     <= pwdata[PERIOD_W-1:0];
                REG_RED:    r_red_peak   <= pwdata[COLOR_W-1:0];
                REG_GREEN:  r_green_peak <= pwdata[COLOR_W-1:0];
                REG_BLUE:   r_blue_peak  <= pwdata[COLOR_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_PERIOD: prdata = {{(32-PERIOD_W){1'b0}}, r_period};
            REG_RED:    prdata = {{(32-COLOR_W){1'b0}}, r_red_peak};
            REG_GREEN:  prdata = {{(32-COLOR_W){1'b0}}, r_green_peak};
            REG_BLUE:   prdata = {{(32-COLOR_W){1'b0}}, r_blue_peak};
            default:    prdata = '0;
        endcase
    end

    // Handshakes.
    assign i_tick.ready = (r_state == S_IDLE);
    assign tick_acc     = i_tick.valid && i_tick.ready;
    assign out_free     = !r_out_valid || o_glow.ready;

    // Combinational helpers of the datapath.
    always_comb begin
        p_eff     = (r_period == '0) ? PERIOD_W'(1) : r_period;
        mod_sum   = {1'b0, r_time} + {1'b0, i_tick.elapsed_us};
        phase     = div_quot[PHASE_BITS-1:0];
        phase_ext = {1'b0, phase};
        // Fold the phase onto the first quarter wave.
        fold      = (phase_ext > (PHASE_BITS+1)'(HALF))
                    ? (PHASE_BITS+1)'(N_PHASE) - phase_ext : phase_ext;
        x_val     = r_prod[PHASE_BITS +: 32];
        tdc       = taylor_const(r_k);
        tdiv_num  = 32'(r_prod[62:30] >> tdc.pre);
        q_est     = 32'(r_prod >> (7'd32 + {4'd0, tdc.post}));
        // The estimate is at most one short, so the remainder is below twice the odd
        // factor and its low eight bits are exact.
        rem_lo    = r_num_lo - r_prod[7:0];
        term_q    = r_qe + {31'd0, (rem_lo >= {1'b0, tdc.odd})};
        if (r_sum[33]) begin
            s_val = '0;
        end else if (r_sum > 34'sd1073741824) begin
            s_val = ONE_Q30;
        end else begin
            s_val = r_sum[30:0];
        end
        g_round   = r_prod[60:0] + (61'd1 << 43);
    end

    // Shared multiplier operand selection.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_MULX: begin
                mul_a = PI_Q30;
                mul_b = {{(32-PHASE_BITS){1'b0}}, r_q};
            end
            S_MULX2: begin
                mul_a = x_val;
                mul_b = x_val;
            end
            S_TMUL: begin
                mul_a = r_term;
                mul_b = r_x2;
            end
            S_TDIV_GO: begin
                mul_a = tdiv_num;
                mul_b = tdc.recip;
            end
            S_TDIV: begin
                mul_a = q_est;
                mul_b = {25'd0, tdc.odd};
            end
            S_SQ: begin
                mul_a = {1'b0, s_val};
                mul_b = {1'b0, s_val};
            end
            S_CR: begin
                mul_a = {{(32-COLOR_W){1'b0}}, r_red_peak};
                mul_b = {16'd0, r_g};
            end
            S_CG: begin
                mul_a = {{(32-COLOR_W){1'b0}}, r_green_peak};
                mul_b = {16'd0, r_g};
            end
            S_CB: begin
                mul_a = {{(32-COLOR_W){1'b0}}, r_blue_peak};
                mul_b = {16'd0, r_g};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // Divider requests: modulo on a tick, then the phase after the modulo.
    always_comb begin
        div_ctl.start = 1'b0;
        div_ctl.nbits = '0;
        div_dividend  = '0;
        div_divisor   = r_p;
        case (r_state)
            S_IDLE: begin
                div_ctl.start = tick_acc;
                div_ctl.nbits = DIV_CNT_W'(MOD_BITS);
                div_dividend  = DIVW'(mod_sum) << (DIVW - MOD_BITS);
                div_divisor   = p_eff;
            end
            S_MOD: begin
                div_ctl.start = div_done;
                div_ctl.nbits = DIV_CNT_W'(PH_BITS);
                div_dividend  = DIVW'(div_rem) << (DIVW - PERIOD_W);
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (tick_acc) n_state = S_MOD;
            S_MOD:     if (div_done) n_state = S_PHASE;
            S_PHASE:   if (div_done) n_state = S_MULX;
            S_MULX:    n_state = S_MULX2;
            S_MULX2:   n_state = S_X2;
            S_X2:      n_state = S_TMUL;
            S_TMUL:    n_state = S_TDIV_GO;
            S_TDIV_GO: n_state = S_TDIV;
            S_TDIV:    n_state = S_TFIX;
            S_TFIX:    n_state = (r_k == 3'd7) ? S_SQ : S_TMUL;
            S_SQ:      n_state = S_G;
            S_G:       n_state = S_CR;
            S_CR:      n_state = S_CG;
            S_CG:      n_state = S_CB;
            S_CB:      n_state = S_CD;
            S_CD:      n_state = S_CW;
            S_CW:      if (out_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_time  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MOD && div_done) begin
                r_time <= div_rem;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: if (tick_acc) r_p <= p_eff;
            S_PHASE: if (div_done) r_q <= fold[PHASE_BITS-1:0];
            S_MULX2: begin
                r_term <= x_val;
                r_sum  <= $signed({2'b00, x_val});
            end
            S_X2: begin
                r_x2 <= r_prod[61:30];
                r_k  <= 3'd1;
            end
            S_TDIV_GO: r_num_lo <= tdiv_num[7:0];
            S_TDIV: r_qe <= q_est;
            S_TFIX: begin
                r_term <= term_q;
                // Odd terms of the sine series are subtracted.
                if (r_k[0]) begin
                    r_sum <= r_sum - $signed({2'b00, term_q});
                end else begin
                    r_sum <= r_sum + $signed({2'b00, term_q});
                end
                r_k <= r_k + 3'd1;
            end
            S_G: r_g <= g_round[60] ? 16'hFFFF : g_round[59:44];
            S_CG: r_lvl_r <= r_prod[16 +: COLOR_W];
            S_CB: r_lvl_g <= r_prod[16 +: COLOR_W];
            S_CD: r_lvl_b <= r_prod[16 +: COLOR_W];
            default: ;
        endcase
    end

    // Output register: the result beat waits here until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_CW && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_glow.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_CW && out_free) begin
            r_red_out   <= r_lvl_r;
            r_green_out <= r_lvl_g;
            r_blue_out  <= r_lvl_b;
        end
    end

    assign o_glow.valid     = r_out_valid;
    assign o_glow.red_out   = r_red_out;
    assign o_glow.green_out = r_green_out;
    assign o_glow.blue_out  = r_blue_out;

    // The stored time lies inside the period once the modulo has finished.
    a_time_in_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PHASE) |-> (r_time < r_p))
        else $error("time in period not below the period");

    // The folded phase never exceeds a quarter wave.
    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MULX) |-> (r_q <= PHASE_BITS'(HALF)))
        else $error("folded phase out of range");

    // Series terms are only worked on for k from one to seven.
    a_term_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TMUL || r_state == S_TDIV) |-> (r_k != 3'd0))
        else $error("series term index out of range");

    // An accepted tick keeps the block busy on the following cycle.
    a_busy_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tick_acc |=> !i_tick.ready)
        else $error("tick taken while the previous one is in progress");

endmodule
